// File: hw/rtl/iff_pkg.sv
// Shared constants, types and helpers for the integer field formatter.
package iff_pkg;

	localparam int unsigned VALUE_W         = 32;
	localparam int unsigned FW_W            = 6;
	localparam int unsigned CHAR_W          = 8;
	localparam int unsigned DIGIT_W         = 4;
	localparam int unsigned MAX_FIELD_WIDTH = 32;
	localparam int unsigned MAX_DIGITS      = 10;
	localparam int unsigned DIDX_W          = $clog2(MAX_DIGITS);
	localparam int unsigned DCNT_W          = $clog2(MAX_DIGITS + 1);

	// floor(x / 10) == (x * RECIP_10) >> RECIP_SHIFT for every 32-bit x
	localparam logic [VALUE_W-1:0] RECIP_10    = 32'hCCCC_CCCD;
	localparam int unsigned        RECIP_SHIFT = 35;

	localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;
	localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;

	typedef logic [DIGIT_W-1:0] digit_t;

	function automatic logic [CHAR_W-1:0] digit_char(input digit_t d, input logic up);
		logic [CHAR_W-1:0] base;
		base = up ? CHAR_UPPER_A : CHAR_LOWER_A;
		if (d < DIGIT_W'(10)) begin
			digit_char = CHAR_ZERO + CHAR_W'(d);
		end else begin
			digit_char = base + CHAR_W'(d - DIGIT_W'(10));
		end
	endfunction

endpackage

// File: hw/rtl/iff_if.sv
// Channel interfaces: input value transactions and output character transactions.
interface iff_item_if import iff_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [VALUE_W-1:0]       value;
	logic                     hex_base;
	logic                     signed_mode;
	logic [FW_W-1:0]          field_width;
	logic                     left_align;
	logic                     zero_fill;
	logic                     upper_case;

	modport source(output valid, value, hex_base, signed_mode, field_width, left_align,
		zero_fill, upper_case, input ready);
	modport sink(input valid, value, hex_base, signed_mode, field_width, left_align,
		zero_fill, upper_case, output ready);
endinterface

interface iff_char_if import iff_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_out;
	logic              last_char;

	modport source(output valid, char_out, last_char, input ready);
	modport sink(input valid, char_out, last_char, output ready);
endinterface

// File: hw/rtl/iff_digit_unit.sv
// Shared divide-by-base step: quotient of the working value and the digit it leaves.
module iff_digit_unit import iff_pkg::*; (
	input  logic               hex,
	input  logic [VALUE_W-1:0] operand,
	output logic [VALUE_W-1:0] quotient,
	input  logic [VALUE_W-1:0] prev,
	input  logic [VALUE_W-1:0] prev_quot,
	output digit_t             digit
);

	logic [2*VALUE_W-1:0] prod;
	logic [DIGIT_W-1:0]   q10_low;

	// reciprocal multiply for base 10, plain shift for base 16
	assign prod     = {{VALUE_W{1'b0}}, operand} * {{VALUE_W{1'b0}}, RECIP_10};
	assign quotient = hex ? (operand >> DIGIT_W)
		: VALUE_W'(prod[2*VALUE_W-1:RECIP_SHIFT]);

	// remainder only needs the low nibble: prev - 10*q (or - 16*q, low nibble zero)
	assign q10_low = {prev_quot[0], 3'b000} + {prev_quot[2:0], 1'b0};
	assign digit   = hex ? prev[DIGIT_W-1:0] : prev[DIGIT_W-1:0] - q10_low;

endmodule

// File: hw/rtl/integer_field_formatter_top.sv
// Integer field formatter: one value transaction in, its printf-style characters out.
// Flow: conversion stores one digit per cycle, then a setup state lays out the field and
//   characters leave through the output register, one per cycle while chars.ready is high.
// A new transaction is accepted only in idle, once the last character of the previous field
//   is loaded; the divide unit and the single output register set the pace.
// Reset (arst_n low): sequencer idle, output register empty; digit store not cleared.
module integer_field_formatter_top import iff_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	iff_item_if.sink     item,
	iff_char_if.source   chars
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CONV,
		S_SETUP,
		S_LSIGN,
		S_PADL,
		S_TSIGN,
		S_DIGIT,
		S_PADR
	} state_t;

	state_t              state_q;
	logic [VALUE_W-1:0]  cur_q;      // remaining value fed to the divide unit
	logic [VALUE_W-1:0]  prev_q;     // value one step behind, source of the digit
	logic                primed_q;   // prev_q/cur_q pair is valid
	logic [DCNT_W-1:0]   dcnt_q;
	logic [FW_W-1:0]     w_q;
	logic                neg_q, hex_q, left_q, zf_q, up_q;
	logic                tsign_q, padr_q;
	logic [FW_W-1:0]     cnt_q;      // pad characters still to send
	logic [CHAR_W-1:0]   padch_q;
	logic                ovalid_q;
	logic [CHAR_W-1:0]   char_q;
	logic                last_q;
	digit_t              digit_store_q [MAX_DIGITS];

	logic [VALUE_W-1:0]  quot;
	digit_t              digit;
	logic                accept;
	logic                can_load;
	logic                load_char;  // an emit state loads the output register
	logic                neg_in;
	logic [VALUE_W-1:0]  mag_in;

	// field layout, worked out once conversion has the digit count
	logic                lead;
	logic [FW_W-1:0]     w2, len, padn;
	logic                padl_now;

	iff_digit_unit u_digit (
		.hex       (hex_q),
		.operand   (cur_q),
		.quotient  (quot),
		.prev      (prev_q),
		.prev_quot (cur_q),
		.digit     (digit)
	);

	assign item.ready = (state_q == S_IDLE);
	assign accept     = item.valid && item.ready;
	assign can_load   = !ovalid_q || chars.ready;
	assign load_char  = can_load && (state_q == S_LSIGN || state_q == S_PADL
		|| state_q == S_TSIGN || state_q == S_DIGIT || state_q == S_PADR);

	assign chars.valid     = ovalid_q;
	assign chars.char_out  = char_q;
	assign chars.last_char = last_q;

	assign neg_in = !item.hex_base && item.signed_mode && item.value[VALUE_W-1];
	assign mag_in = neg_in ? (VALUE_W'(0) - item.value) : item.value;

	// a negative value with zero fill and a width sends its sign ahead of the padding
	assign lead     = neg_q && zf_q && (w_q != '0);
	assign w2       = w_q - FW_W'(lead);
	assign len      = FW_W'(dcnt_q) + FW_W'(neg_q && !lead);
	assign padn     = (w2 > len) ? (w2 - len) : '0;
	assign padl_now = !left_q && (padn != '0);

	always_ff @(posedge clk) begin
		if (state_q == S_CONV && primed_q) begin
			digit_store_q[dcnt_q[DIDX_W-1:0]] <= digit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cur_q    <= '0;
			prev_q   <= '0;
			primed_q <= 1'b0;
			dcnt_q   <= '0;
			w_q      <= '0;
			neg_q    <= 1'b0;
			hex_q    <= 1'b0;
			left_q   <= 1'b0;
			zf_q     <= 1'b0;
			up_q     <= 1'b0;
			tsign_q  <= 1'b0;
			padr_q   <= 1'b0;
			cnt_q    <= '0;
			padch_q  <= CHAR_SPACE;
			ovalid_q <= 1'b0;
			char_q   <= '0;
			last_q   <= 1'b0;
		end else begin
			// drained with nothing new to load
			if (ovalid_q && chars.ready && !load_char) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cur_q    <= mag_in;
						primed_q <= 1'b0;
						dcnt_q   <= '0;
						w_q      <= (item.field_width > FW_W'(MAX_FIELD_WIDTH))
							? FW_W'(MAX_FIELD_WIDTH) : item.field_width;
						neg_q    <= neg_in;
						hex_q    <= item.hex_base;
						left_q   <= item.left_align;
						zf_q     <= item.zero_fill;
						up_q     <= item.upper_case;
						state_q  <= S_CONV;
					end
				end
				S_CONV: begin
					// one digit per cycle, least significant first
					cur_q    <= quot;
					prev_q   <= cur_q;
					primed_q <= 1'b1;
					if (primed_q) begin
						dcnt_q <= dcnt_q + DCNT_W'(1);
						if (cur_q == '0) begin
							state_q <= S_SETUP;
						end
					end
				end
				S_SETUP: begin
					tsign_q <= neg_q && !lead;
					padr_q  <= left_q && (padn != '0);
					cnt_q   <= padn;
					padch_q <= (w_q != '0 && zf_q) ? CHAR_ZERO : CHAR_SPACE;
					priority if (lead) begin
						state_q <= S_LSIGN;
					end else if (padl_now) begin
						state_q <= S_PADL;
					end else if (neg_q) begin
						state_q <= S_TSIGN;
					end else begin
						state_q <= S_DIGIT;
					end
				end
				S_LSIGN: begin
					if (can_load) begin
						ovalid_q <= 1'b1;
						char_q   <= CHAR_MINUS;
						last_q   <= 1'b0;
						state_q  <= (cnt_q != '0 && !left_q) ? S_PADL : S_DIGIT;
					end
				end
				S_PADL: begin
					if (can_load) begin
						ovalid_q <= 1'b1;
						char_q   <= padch_q;
						last_q   <= 1'b0;
						cnt_q    <= cnt_q - FW_W'(1);
						if (cnt_q == FW_W'(1)) begin
							state_q <= tsign_q ? S_TSIGN : S_DIGIT;
						end
					end
				end
				S_TSIGN: begin
					if (can_load) begin
						ovalid_q <= 1'b1;
						char_q   <= CHAR_MINUS;
						last_q   <= 1'b0;
						state_q  <= S_DIGIT;
					end
				end
				S_DIGIT: begin
					// most significant first, reading the store back down
					if (can_load) begin
						ovalid_q <= 1'b1;
						char_q   <= digit_char(
							digit_store_q[DIDX_W'(dcnt_q - DCNT_W'(1))], up_q);
						dcnt_q   <= dcnt_q - DCNT_W'(1);
						last_q   <= (dcnt_q == DCNT_W'(1)) && !padr_q;
						if (dcnt_q == DCNT_W'(1)) begin
							state_q <= padr_q ? S_PADR : S_IDLE;
						end
					end
				end
				S_PADR: begin
					if (can_load) begin
						ovalid_q <= 1'b1;
						char_q   <= padch_q;
						cnt_q    <= cnt_q - FW_W'(1);
						last_q   <= (cnt_q == FW_W'(1));
						if (cnt_q == FW_W'(1)) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// a new transaction always starts conversion with an unprimed divide pipe
	a_accept_starts_conv: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_CONV) && !primed_q && (dcnt_q == '0))
		else $error("conversion not started cleanly");

	// the digit store never overflows during conversion
	a_dcnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CONV) |-> (dcnt_q < DCNT_W'(MAX_DIGITS)))
		else $error("digit count exceeds store depth");

	// digit emission always has a stored digit to read
	a_digit_present: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIGIT) |-> (dcnt_q != '0))
		else $error("digit emission with empty store");

	// loading the final character returns the sequencer to idle
	a_last_ends_field: assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && last_q && !$stable(char_q)) || (ovalid_q && $rose(last_q))
		|-> (state_q == S_IDLE))
		else $error("final character loaded without ending the field");

	// pad states only run with pad characters left
	a_pad_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PADL || state_q == S_PADR) |-> (cnt_q != '0))
		else $error("pad state with zero pad count");

endmodule
